>>> rtl/fopp_pkg.sv
// ----------------------------------------------------------------------------
// fopp_pkg
// shared types and constants of the fee-ordered priority pool
// ----------------------------------------------------------------------------
package fopp_pkg;

  localparam int unsigned ENTRY_W = 64 + 64 + 32 + 64 + 4 + 2;
  localparam int unsigned MAX_RESULTS = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FETCH  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RESP_INSERT = 2'd0,
    RESP_FETCH  = 2'd1,
    RESP_REMOVE = 2'd2
  } resp_t;

  typedef struct packed {
    logic [63:0] tx_id;
    logic [63:0] fee;
    logic [31:0] timestamp;
    logic [63:0] amount;
    logic [3:0]  kind;
    logic [1:0]  status;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_FET_SCAN,
    ST_RESP,
    ST_WAIT
  } state_t;

endpackage

>>> rtl/fopp_if.sv
// ----------------------------------------------------------------------------
// fopp_in_if / fopp_out_if
// request and result channels of the pool
// ----------------------------------------------------------------------------
interface fopp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] tx_id;
  logic [63:0] fee;
  logic [31:0] timestamp;
  logic [63:0] amount;
  logic [3:0]  tx_kind;
  logic [1:0]  entry_status;
  logic [6:0]  fetch_limit;
  logic        batch_last;
  modport source (output valid, cmd, tx_id, fee, timestamp, amount, tx_kind,
                  entry_status, fetch_limit, batch_last, input ready);
  modport sink (input valid, cmd, tx_id, fee, timestamp, amount, tx_kind,
                entry_status, fetch_limit, batch_last, output ready);
endinterface

interface fopp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  resp_kind;
  logic        ok;
  logic [63:0] out_tx_id;
  logic [63:0] out_amount;
  logic [3:0]  out_kind;
  logic [31:0] out_timestamp;
  logic        last;
  modport source (output valid, resp_kind, ok, out_tx_id, out_amount, out_kind,
                  out_timestamp, last, input ready);
  modport sink (input valid, resp_kind, ok, out_tx_id, out_amount, out_kind,
                out_timestamp, last, output ready);
endinterface

>>> rtl/fopp_ram.sv
// ----------------------------------------------------------------------------
// fopp_ram
// single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module fopp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/fee_ordered_priority_pool.sv
// ----------------------------------------------------------------------------
// fee_ordered_priority_pool
// sorted pool of entries, highest fee then oldest timestamp first
// ----------------------------------------------------------------------------
// The pool keeps up to POOL_DEPTH entries in one ram, in sorted order. A
// request is taken only when the block is idle; each request walks the ram
// one entry per cycle through its single read port, except while a fetch
// waits for the receiver to take a result. An insert scans to the sorted
// position and then shifts the tail up one slot at a time, and an insert
// into a full pool goes straight to its result; a remove scans for the id
// and shifts the tail down; a fetch reads entries in order and streams each
// pending one as a result, reading a slot again while the receiver holds
// off a waiting result. After its final result is issued the block passes
// through a wait state before the next request can be taken. Every request
// gives exactly one result, except a fetch that may give up to 64 and the
// unused command code, which gives none. A fetch holds each pending entry
// back until it knows whether another follows, so that the final one
// carries last. Results wait in an output register; there is no clearing
// pass after reset.
module fee_ordered_priority_pool #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  fopp_in_if.sink    in_req,
  fopp_out_if.source out_res
);
  import fopp_pkg::*;

  localparam int unsigned AW = $clog2(POOL_DEPTH);
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // slot being read this cycle
  logic          rd_pend_r, rd_pend_nxt; // ram data for idx-1 is valid
  logic [6:0]    cnt_r, cnt_nxt;      // fetch results remaining
  logic [CW-1:0] pos_r, pos_nxt;      // insert position
  logic          any_r, any_nxt;
  entry_t        req_r;
  logic [1:0]    cmd_r;

  // fetched entry held back until the next one or the end is known
  logic          hv_r, hv_nxt;
  entry_t        hent_r, hent_nxt;

  // result register
  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic        ook_r, ook_nxt;
  logic        olast_r, olast_nxt;
  entry_t      oent_r, oent_nxt;

  // ram port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  fopp_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic out_free;
  assign out_free = !ov_r || out_res.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  // data word of slot idx_r-1, valid when rd_pend_r
  logic [CW-1:0] prev_idx;
  assign prev_idx = idx_r - CW'(1);

  logic ins_here;
  assign ins_here = (rdata.fee < req_r.fee) ||
                    (rdata.fee == req_r.fee && rdata.timestamp > req_r.timestamp);

  // pending entry read back during a fetch, with room under the limit
  logic fet_take;
  assign fet_take = rd_pend_r && rdata.status == 2'd0 && cnt_r != '0;

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    any_nxt     = any_r;
    hv_nxt      = hv_r;
    hent_nxt    = hent_r;
    ov_nxt      = ov_r && !out_res.ready;
    okind_nxt   = okind_r;
    ook_nxt     = ook_r;
    olast_nxt   = olast_r;
    oent_nxt    = oent_r;
    we          = 1'b0;
    waddr       = prev_idx[AW-1:0];
    wdata       = rdata;
    raddr       = idx_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_req.valid) begin
          unique case (cmd_t'(in_req.cmd))
            CMD_INSERT: state_nxt = (fill_r >= CW'(POOL_DEPTH)) ? ST_RESP : ST_INS_SCAN;
            CMD_FETCH: begin
              state_nxt = ST_FET_SCAN;
              cnt_nxt   = (in_req.fetch_limit > 7'(MAX_RESULTS)) ?
                          7'(MAX_RESULTS) : in_req.fetch_limit;
            end
            CMD_REMOVE: state_nxt = ST_REM_SCAN;
            default:    state_nxt = ST_IDLE;
          endcase
          any_nxt = 1'b0;
          hv_nxt  = 1'b0;
        end
      end
      ST_INS_SCAN: begin
        // read slot idx, compare its data in the next cycle
        if (rd_pend_r && ins_here) begin
          idx_nxt   = fill_r;           // position is prev_idx
          pos_nxt   = prev_idx;
          state_nxt = ST_INS_SHIFT;
        end else if (idx_r == fill_r) begin
          pos_nxt   = fill_r;
          idx_nxt   = fill_r;
          state_nxt = ST_INS_PUT;
        end else begin
          idx_nxt     = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
      end
      ST_INS_SHIFT: begin
        // move slot idx-1 to idx, walking down to the insert position
        raddr = prev_idx[AW-1:0];
        if (rd_pend_r) begin
          we    = 1'b1;
          waddr = idx_r[AW-1:0];
          wdata = rdata;
          idx_nxt = prev_idx;
          if (prev_idx == pos_r) begin
            state_nxt = ST_INS_PUT;
          end else begin
            raddr       = AW'(prev_idx - CW'(1));
            rd_pend_nxt = 1'b1;
          end
        end else begin
          rd_pend_nxt = 1'b1;
        end
      end
      ST_INS_PUT: begin
        we        = 1'b1;
        waddr     = pos_r[AW-1:0];
        wdata     = req_r;
        fill_nxt  = fill_r + CW'(1);
        any_nxt   = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_REM_SCAN: begin
        if (rd_pend_r && rdata.tx_id == req_r.tx_id) begin
          any_nxt   = 1'b1;
          idx_nxt   = idx_r;           // slot idx moves to idx-1
          state_nxt = ST_REM_SHIFT;
          rd_pend_nxt = 1'b0;
        end else if (idx_r == fill_r) begin
          state_nxt = ST_RESP;
        end else begin
          idx_nxt     = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
      end
      ST_REM_SHIFT: begin
        if (rd_pend_r) begin
          we    = 1'b1;
          waddr = AW'(idx_r - CW'(2));
          wdata = rdata;
        end
        if (idx_r == fill_r) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = ST_RESP;
        end else begin
          idx_nxt     = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
      end
      ST_FET_SCAN: begin
        if (fet_take && hv_r && !out_free) begin
          // held entry cannot leave yet, read the same slot again
          raddr       = prev_idx[AW-1:0];
          rd_pend_nxt = 1'b1;
        end else begin
          if (fet_take) begin
            // another pending entry follows, so the held one is not last
            if (hv_r) begin
              ov_nxt    = 1'b1;
              okind_nxt = RESP_FETCH;
              ook_nxt   = 1'b1;
              olast_nxt = 1'b0;
              oent_nxt  = hent_r;
            end
            hv_nxt   = 1'b1;
            hent_nxt = rdata;
            cnt_nxt  = cnt_r - 7'd1;
          end
          if (idx_r == fill_r || cnt_r == '0 || (fet_take && cnt_r == 7'd1)) begin
            state_nxt = ST_RESP;
          end else begin
            idx_nxt     = idx_r + CW'(1);
            rd_pend_nxt = 1'b1;
          end
        end
      end
      ST_RESP: begin
        // acks, the empty fetch result, or the final fetched entry
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = (cmd_r == CMD_INSERT) ? RESP_INSERT :
                      (cmd_r == CMD_FETCH) ? RESP_FETCH : RESP_REMOVE;
          ook_nxt   = any_r || hv_r;
          olast_nxt = 1'b1;
          oent_nxt  = hv_r ? hent_r : '0;
          hv_nxt    = 1'b0;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      idx_r     <= '0;
      rd_pend_r <= 1'b0;
      cnt_r     <= '0;
      any_r     <= 1'b0;
      hv_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      rd_pend_r <= rd_pend_nxt;
      cnt_r     <= cnt_nxt;
      any_r     <= any_nxt;
      hv_r      <= hv_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    ook_r   <= ook_nxt;
    olast_r <= olast_nxt;
    oent_r  <= oent_nxt;
    hent_r  <= hent_nxt;
    pos_r   <= pos_nxt;
    if (state_r == ST_IDLE && in_req.valid) begin
      cmd_r  <= in_req.cmd;
      req_r  <= '{tx_id: in_req.tx_id, fee: in_req.fee, timestamp: in_req.timestamp,
                  amount: in_req.amount, kind: in_req.tx_kind,
                  status: in_req.entry_status};
    end
  end

  assign out_res.valid         = ov_r;
  assign out_res.resp_kind     = okind_r;
  assign out_res.ok            = ook_r;
  assign out_res.out_tx_id     = oent_r.tx_id;
  assign out_res.out_amount    = oent_r.amount;
  assign out_res.out_kind      = oent_r.kind;
  assign out_res.out_timestamp = oent_r.timestamp;
  assign out_res.last          = olast_r;
endmodule

>>> bench/fopp_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fopp_scoreboard
// watches the request and result channels of the pool, keeps its own sorted
// copy of the pool, works out the results of every request and checks each
// result against the oldest one still owed
// ----------------------------------------------------------------------------
module fopp_scoreboard #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  fopp_in_if   mon_in,
  fopp_out_if  mon_out,
  output int   errors,
  output int   owed
);
  import fopp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [63:0] tx_id;
    logic [63:0] amount;
    logic [3:0]  tx_kind;
    logic [31:0] timestamp;
    logic        last;
  } result_t;

  entry_t      pool [POOL_DEPTH];
  int unsigned fill;
  result_t     owed_q [$];

  assign owed = owed_q.size();

  function automatic result_t ack(logic [1:0] kind, logic ok);
    result_t r;
    r = '0;
    r.kind = kind;
    r.ok = ok;
    r.last = 1'b1;
    return r;
  endfunction

  // updates the pool copy for one request and queues what it must produce
  task automatic apply_request(input logic [1:0] c, input entry_t e, input logic [6:0] lim);
    int unsigned pos;
    int unsigned cap;
    int          n;
    result_t     r;
    bit          found;
    case (c)
      CMD_INSERT: begin
        if (fill >= POOL_DEPTH) begin
          owed_q.push_back(ack(RESP_INSERT, 1'b0));
        end else begin
          pos = fill;
          for (int unsigned i = 0; i < fill; i++) begin
            if (pool[i].fee < e.fee ||
                (pool[i].fee == e.fee && pool[i].timestamp > e.timestamp)) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = fill; i > pos; i--) pool[i] = pool[i-1];
          pool[pos] = e;
          fill++;
          owed_q.push_back(ack(RESP_INSERT, 1'b1));
        end
      end
      CMD_FETCH: begin
        cap = (lim > MAX_RESULTS) ? MAX_RESULTS : lim;
        n = 0;
        for (int unsigned i = 0; i < fill && n < cap; i++) begin
          if (pool[i].status == 2'd0) begin
            r = '0;
            r.kind = RESP_FETCH;
            r.ok = 1'b1;
            r.tx_id = pool[i].tx_id;
            r.amount = pool[i].amount;
            r.tx_kind = pool[i].kind;
            r.timestamp = pool[i].timestamp;
            r.last = (n + 1 == cap);
            owed_q.push_back(r);
            n++;
          end
        end
        if (n == 0) owed_q.push_back(ack(RESP_FETCH, 1'b0));
        else owed_q[$].last = 1'b1;
      end
      CMD_REMOVE: begin
        found = 0;
        for (int unsigned i = 0; i < fill; i++) begin
          if (pool[i].tx_id == e.tx_id) begin
            for (int unsigned j = i; j + 1 < fill; j++) pool[j] = pool[j+1];
            fill--;
            found = 1;
            break;
          end
        end
        owed_q.push_back(ack(RESP_REMOVE, found));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    entry_t  e;
    result_t got;
    result_t exp;
    if (!rst_n) begin
      fill = 0;
      owed_q.delete();
      errors = 0;
    end else begin
      if (mon_in.valid && mon_in.ready) begin
        e.tx_id = mon_in.tx_id;
        e.fee = mon_in.fee;
        e.timestamp = mon_in.timestamp;
        e.amount = mon_in.amount;
        e.kind = mon_in.tx_kind;
        e.status = mon_in.entry_status;
        apply_request(mon_in.cmd, e, mon_in.fetch_limit);
      end
      if (mon_out.valid && mon_out.ready) begin
        got.kind = mon_out.resp_kind;
        got.ok = mon_out.ok;
        got.tx_id = mon_out.out_tx_id;
        got.amount = mon_out.out_amount;
        got.tx_kind = mon_out.out_kind;
        got.timestamp = mon_out.out_timestamp;
        got.last = mon_out.last;
        if (owed_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with none owed: %p", $realtime, got);
        end else begin
          exp = owed_q.pop_front();
          if (got.kind !== exp.kind || got.ok !== exp.ok || got.tx_id !== exp.tx_id ||
              got.amount !== exp.amount || got.tx_kind !== exp.tx_kind ||
              got.timestamp !== exp.timestamp || got.last !== exp.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch\n  exp %p\n  got %p", $realtime, exp, got);
          end
        end
      end
    end
  end

endmodule

>>> bench/fee_ordered_priority_pool_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fee_ordered_priority_pool_test
// drives insert, fetch and remove requests into the pool with random gaps
// and output stalls; the scoreboard beside the block checks every result
// ----------------------------------------------------------------------------
module fee_ordered_priority_pool_test;
  import fopp_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned N_RANDOM = 290;

  logic clk;
  logic rst_n;
  int   errors;
  int   owed;
  bit   quiet;      // no idling in the closing stretch
  bit   hold_req;   // asks the receiver for one long hold-off

  fopp_in_if  in_req ();
  fopp_out_if out_res ();

  fee_ordered_priority_pool #(.POOL_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req.sink),
    .out_res(out_res.source)
  );

  fopp_scoreboard #(.POOL_DEPTH(DEPTH)) sb (
    .clk    (clk),
    .rst_n  (rst_n),
    .mon_in (in_req),
    .mon_out(out_res),
    .errors (errors),
    .owed   (owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("fee_ordered_priority_pool_test: done, errors");
    $finish;
  end

  // receiver: short random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall_left = 400;
        out_res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // one request, held until the block takes it
  task automatic send_req(input cmd_t c, input logic [63:0] id, input logic [63:0] fee,
                          input logic [31:0] ts, input logic [63:0] amt,
                          input logic [3:0] kind, input logic [1:0] st,
                          input logic [6:0] lim);
    in_req.valid <= 1'b1;
    in_req.cmd <= c;
    in_req.tx_id <= id;
    in_req.fee <= fee;
    in_req.timestamp <= ts;
    in_req.amount <= amt;
    in_req.tx_kind <= kind;
    in_req.entry_status <= st;
    in_req.fetch_limit <= lim;
    in_req.batch_last <= 1'($urandom_range(0, 1));
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // few distinct fees so ties happen, with the extremes mixed in
  function automatic logic [63:0] pick_fee();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      5:       return rand64();
      default: return 64'($urandom_range(1, 6)) * 1000;
    endcase
  endfunction

  function automatic logic [31:0] pick_ts();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      4:       return $urandom;
      default: return $urandom_range(100, 104);
    endcase
  endfunction

  // ids from a small set so that removes mostly hit
  function automatic logic [63:0] pick_id();
    return ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 40));
  endfunction

  function automatic logic [6:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd64;
      2:       return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic random_req(input int ins_weight);
    int   roll;
    cmd_t c;
    roll = $urandom_range(0, 99);
    if (roll < ins_weight) c = CMD_INSERT;
    else if (roll < ins_weight + (95 - ins_weight) / 2) c = CMD_FETCH;
    else if (roll < 95) c = CMD_REMOVE;
    else c = CMD_NONE;
    send_req(c, pick_id(), pick_fee(), pick_ts(), rand64(), 4'($urandom_range(0, 15)),
             ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : 2'd0,
             pick_limit());
  endtask

  initial begin
    quiet = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.cmd = CMD_INSERT;
    in_req.tx_id = '0;
    in_req.fee = '0;
    in_req.timestamp = '0;
    in_req.amount = '0;
    in_req.tx_kind = '0;
    in_req.entry_status = '0;
    in_req.fetch_limit = '0;
    in_req.batch_last = 1'b0;
    out_res.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pool, extremes, ties, every status, odd command
    send_req(CMD_FETCH, '0, '0, '0, '0, '0, '0, 7'd64);          // nothing pending
    send_req(CMD_REMOVE, 64'd5, '0, '0, '0, '0, '0, '0);          // unknown id
    send_req(CMD_INSERT, 64'd1, '0, '0, '0, 4'd0, 2'd0, '0);
    send_req(CMD_INSERT, '1, '1, '1, '1, 4'd15, 2'd0, '0);
    send_req(CMD_INSERT, 64'd2, 64'd500, 32'd7, 64'd11, 4'd3, 2'd0, '0);
    send_req(CMD_INSERT, 64'd3, 64'd500, 32'd7, 64'd12, 4'd4, 2'd0, '0); // exact tie
    send_req(CMD_INSERT, 64'd4, 64'd500, 32'd6, 64'd13, 4'd5, 2'd1, '0); // older wins
    send_req(CMD_INSERT, 64'd6, 64'd500, 32'd9, 64'd14, 4'd6, 2'd2, '0);
    send_req(CMD_INSERT, 64'd7, 64'd900, '1, 64'd15, 4'd9, 2'd3, '0);
    send_req(CMD_FETCH, '0, '0, '0, '0, '0, '0, 7'd0);            // limit zero
    send_req(CMD_FETCH, '0, '0, '0, '0, '0, '0, 7'd2);
    send_req(CMD_FETCH, '0, '0, '0, '0, '0, '0, 7'd127);          // above the bound
    send_req(CMD_NONE, '1, '1, '1, '1, '1, '1, '1);               // no result
    send_req(CMD_REMOVE, 64'd3, '0, '0, '0, '0, '0, '0);
    send_req(CMD_REMOVE, '1, '0, '0, '0, '0, '0, '0);
    send_req(CMD_FETCH, '0, '0, '0, '0, '0, '0, 7'd64);
    send_req(CMD_REMOVE, 64'd3, '0, '0, '0, '0, '0, '0);          // already gone

    // random: a flood of inserts fills the pool and hits the full case,
    // then a balanced mix, with one long receiver hold-off and one drain
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 110) hold_req = 1;
      if (k == 200) begin
        in_req.valid <= 1'b0;
        while (owed != 0) @(posedge clk);
      end
      if (k == N_RANDOM - 40) quiet = 1;
      if (k < 75) random_req(85);
      else if (k < 95) random_req(15);
      else random_req(45);
    end
    in_req.valid <= 1'b0;

    while (owed != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && owed == 0) begin
      $display("fee_ordered_priority_pool_test: done, clean");
    end else begin
      $display("fee_ordered_priority_pool_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fopp_pkg.sv
rtl/fopp_if.sv
rtl/fopp_ram.sv
rtl/fee_ordered_priority_pool.sv
bench/fopp_scoreboard.sv
bench/fee_ordered_priority_pool_test.sv
